>>> design/hjs_pkg.sv
// ----------------------------------------------------------------------------
// hjs_pkg: shared types and tables for the Hangul jamo stream core
// Payload structs, queue entry layout and compatibility jamo lookups.
// ----------------------------------------------------------------------------
package hjs_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  typedef enum logic [1:0] {
    K_NONE  = 2'd0,   // nothing to send, only carries end of string
    K_ASCII = 2'd1,
    K_SYL   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;   // ASCII byte, or final index for a syllable
    logic [8:0] quo;    // syllable offset / 28
    logic       eos;
  } job_t;

  localparam logic [20:0] SYL_BASE     = 21'h00AC00;
  localparam logic [20:0] SYL_LAST     = 21'h00D7A3;
  localparam logic [15:0] MEDIAL_BASE  = 16'h314F;
  localparam int          QDEPTH       = 4;
  localparam int          QAW          = $clog2(QDEPTH);

  function automatic logic [15:0] initial_cp(input logic [4:0] idx);
    logic [15:0] r;
    case (idx)
      5'd0:  r = 16'h3131;
      5'd1:  r = 16'h3132;
      5'd2:  r = 16'h3134;
      5'd3:  r = 16'h3137;
      5'd4:  r = 16'h3138;
      5'd5:  r = 16'h3139;
      5'd6:  r = 16'h3141;
      5'd7:  r = 16'h3142;
      5'd8:  r = 16'h3143;
      5'd9:  r = 16'h3145;
      5'd10: r = 16'h3146;
      5'd11: r = 16'h3147;
      5'd12: r = 16'h3148;
      5'd13: r = 16'h3149;
      5'd14: r = 16'h314A;
      5'd15: r = 16'h314B;
      5'd16: r = 16'h314C;
      5'd17: r = 16'h314D;
      5'd18: r = 16'h314E;
      default: r = 16'h3131;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] final_cp(input logic [4:0] idx);
    logic [15:0] r;
    case (idx)
      5'd1:  r = 16'h3131;
      5'd2:  r = 16'h3132;
      5'd3:  r = 16'h3133;
      5'd4:  r = 16'h3134;
      5'd5:  r = 16'h3135;
      5'd6:  r = 16'h3136;
      5'd7:  r = 16'h3137;
      5'd8:  r = 16'h3139;
      5'd9:  r = 16'h313A;
      5'd10: r = 16'h313B;
      5'd11: r = 16'h313C;
      5'd12: r = 16'h313D;
      5'd13: r = 16'h313E;
      5'd14: r = 16'h313F;
      5'd15: r = 16'h3140;
      5'd16: r = 16'h3141;
      5'd17: r = 16'h3142;
      5'd18: r = 16'h3144;
      5'd19: r = 16'h3145;
      5'd20: r = 16'h3146;
      5'd21: r = 16'h3147;
      5'd22: r = 16'h3148;
      5'd23: r = 16'h314A;
      5'd24: r = 16'h314B;
      5'd25: r = 16'h314C;
      5'd26: r = 16'h314D;
      5'd27: r = 16'h314E;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

>>> design/hjs_front.sv
// ----------------------------------------------------------------------------
// hjs_front: UTF-8 decoder and classifier
// Gathers code points by lead-byte class, splits syllable offsets by 28.
// ----------------------------------------------------------------------------
module hjs_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc_en,
  input  hjs_pkg::in_t  in_data,
  output logic          job_push,
  output hjs_pkg::job_t job
);

  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic        done;
  logic [20:0] cp;
  logic [7:0]  b;
  logic [13:0] off;
  logic [23:0] prod;
  logic [8:0]  quo;
  logic [13:0] rem;

  always_comb begin
    b        = in_data.in_byte;
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    done     = 1'b0;
    cp       = 21'd0;
    if (pend_r != 2'd0) begin
      acc_nxt  = {acc_r[14:0], b[5:0]};
      pend_nxt = pend_r - 2'd1;
      done     = (pend_r == 2'd1);
      cp       = acc_nxt;
    end else if (b[7] == 1'b0) begin
      done = 1'b1;
      cp   = {13'd0, b};
    end else if (b[7:5] == 3'b110) begin
      acc_nxt  = {16'd0, b[4:0]};
      pend_nxt = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      acc_nxt  = {17'd0, b[3:0]};
      pend_nxt = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      acc_nxt  = {18'd0, b[2:0]};
      pend_nxt = 2'd3;
    end
    if (in_data.end_of_string) begin
      pend_nxt = 2'd0;
      acc_nxt  = 21'd0;
    end
  end

  // offset / 28 as (offset >> 2) / 7, reciprocal 2341 / 2^14 exact here
  always_comb begin
    off  = 14'(cp - hjs_pkg::SYL_BASE);
    prod = 24'(off[13:2]) * 24'd2341;
    quo  = prod[22:14];
    rem  = off - 14'(quo) * 14'd28;
  end

  always_comb begin
    job.kind = hjs_pkg::K_NONE;
    job.data = 8'd0;
    job.quo  = quo;
    job.eos  = in_data.end_of_string;
    if (done && cp < 21'h80) begin
      job.kind = hjs_pkg::K_ASCII;
      job.data = cp[7:0];
    end else if (done && cp >= hjs_pkg::SYL_BASE && cp <= hjs_pkg::SYL_LAST) begin
      job.kind = hjs_pkg::K_SYL;
      job.data = {3'd0, rem[4:0]};
    end
    job_push = acc_en && (job.kind != hjs_pkg::K_NONE || in_data.end_of_string);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      acc_r  <= 21'd0;
    end else if (acc_en) begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

>>> design/hjs_queue.sv
// ----------------------------------------------------------------------------
// hjs_queue: short job queue between decoder and expander
// Flop array with head and tail pointers.
// ----------------------------------------------------------------------------
module hjs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  hjs_pkg::job_t wr_job,
  input  logic          rd_en,
  output hjs_pkg::job_t rd_job,
  output logic          q_full,
  output logic          q_empty
);

  hjs_pkg::job_t             mem_r [hjs_pkg::QDEPTH];
  logic [hjs_pkg::QAW-1:0]   wp_r, rp_r;
  logic [hjs_pkg::QAW:0]     cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == (hjs_pkg::QAW+1)'(hjs_pkg::QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_job  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + 1'b1;
    if (!wr_en && rd_en) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> design/hjs_back.sv
// ----------------------------------------------------------------------------
// hjs_back: jamo expander, byte limiter and output register
// Turns one job into 0..9 output bytes, one per cycle while the output slot is free.
// ----------------------------------------------------------------------------
module hjs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [15:0]   limit,
  input  hjs_pkg::job_t head,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output hjs_pkg::out_t out_data
);

  logic          act_r, act_nxt;
  hjs_pkg::kind_t kind_r;
  logic          eos_r;
  logic [7:0]    asc_r;
  logic [15:0]   cps_r [3];
  logic [1:0]    nj_r, jsel_r, jsel_nxt, bsel_r, bsel_nxt;
  logic [15:0]   count_r, count_nxt;
  logic          ovld_r, ovld_nxt;
  hjs_pkg::out_t out_r;

  logic          slot_free, cut, emit, fin, load, last_byte;
  logic [15:0]   cur_cp;
  logic [7:0]    byte_val;
  logic [17:0]   iprod;
  logic [4:0]    ini, med, fidx;
  logic [8:0]    msub;

  assign slot_free = !ovld_r || pop;
  assign cut       = (count_r >= limit);
  assign cur_cp    = cps_r[jsel_r];
  assign empty     = !ovld_r;
  assign out_data  = out_r;

  always_comb begin
    last_byte = (kind_r == hjs_pkg::K_ASCII) ||
                (bsel_r == 2'd2 && jsel_r == nj_r - 2'd1);
    case (bsel_r)
      2'd0:    byte_val = {4'hE, cur_cp[15:12]};
      2'd1:    byte_val = {2'b10, cur_cp[11:6]};
      default: byte_val = {2'b10, cur_cp[5:0]};
    endcase
    if (kind_r == hjs_pkg::K_ASCII) byte_val = asc_r;
  end

  always_comb begin
    emit = 1'b0;
    fin  = 1'b0;
    if (act_r) begin
      if (kind_r == hjs_pkg::K_NONE || cut) begin
        fin = 1'b1;
      end else if (slot_free) begin
        emit = 1'b1;
        fin  = last_byte || (count_r + 16'd1 == limit);
      end
    end
    load    = !q_empty && (!act_r || fin);
    q_pop   = load;
    act_nxt = load ? 1'b1 : (fin ? 1'b0 : act_r);

    count_nxt = emit ? count_r + 16'd1 : count_r;
    if (fin && eos_r) count_nxt = 16'd0;

    jsel_nxt = jsel_r;
    bsel_nxt = bsel_r;
    if (emit) begin
      if (bsel_r == 2'd2) begin
        bsel_nxt = 2'd0;
        jsel_nxt = jsel_r + 2'd1;
      end else begin
        bsel_nxt = bsel_r + 2'd1;
      end
    end
    if (load) begin
      jsel_nxt = 2'd0;
      bsel_nxt = 2'd0;
    end

    ovld_nxt = emit ? 1'b1 : (pop ? 1'b0 : ovld_r);
  end

  // quotient / 21 by reciprocal 391 / 2^13, exact for quotients below 431
  always_comb begin
    iprod = 18'(head.quo) * 18'd391;
    ini   = iprod[17:13];
    msub  = head.quo - 9'(ini) * 9'd21;
    med   = msub[4:0];
    fidx  = head.data[4:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= head.kind;
      eos_r    <= head.eos;
      asc_r    <= head.data;
      cps_r[0] <= hjs_pkg::initial_cp(ini);
      cps_r[1] <= hjs_pkg::MEDIAL_BASE + 16'(med);
      cps_r[2] <= hjs_pkg::final_cp(fidx);
      nj_r     <= (fidx != 5'd0) ? 2'd3 : 2'd2;
    end
    if (emit) begin
      out_r.out_byte    <= byte_val;
      out_r.last_of_run <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      count_r <= 16'd0;
      jsel_r  <= 2'd0;
      bsel_r  <= 2'd0;
      ovld_r  <= 1'b0;
    end else begin
      act_r   <= act_nxt;
      count_r <= count_nxt;
      jsel_r  <= jsel_nxt;
      bsel_r  <= bsel_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

>>> design/utf8_hangul_to_jamo_stream_core.sv
// ----------------------------------------------------------------------------
// utf8_hangul_to_jamo_stream_core: UTF-8 Hangul syllable to jamo stream
// Decodes UTF-8 bytes, splits syllables into compatibility jamo bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write: a request {in_byte, end_of_string} is taken
//   on a clock edge with push high and full low. Output side is a queue
//   read: while empty is low the oldest output byte sits on out_data and is
//   taken on an edge with pop high. last_of_run marks the final byte that
//   one input byte produced.
//   cfg_data (out_byte_limit) is written when cfg_valid and cfg_ready; ready
//   is always high. Write it only while the core is idle.
// Path: an accepted input is written into the job queue, then loaded into
//   the expander registers; its bytes leave through the output register.
// Throughput: the expander sends one byte per cycle while the output
//   register is free (pop high or empty); an ASCII byte gives one byte,
//   a syllable 6 or 9 (two or three 3-byte jamo). A 4-entry job queue
//   lets the decoder keep taking input bytes while the expander sends.
// Stall: when pop is held low the output register holds, the expander
//   stops, the queue fills and full rises.
// Reset: synchronous rst_n clears decoder state, queue, byte counter and
//   output; the limit returns to 511.
// ----------------------------------------------------------------------------
module utf8_hangul_to_jamo_stream_core (
  input  logic          clk,
  input  logic          rst_n,
  // input channel
  input  logic          push,
  output logic          full,
  input  hjs_pkg::in_t  in_data,
  // result channel
  input  logic          pop,
  output logic          empty,
  output hjs_pkg::out_t out_data,
  // configuration
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);

  logic [15:0]   limit_r;
  logic          acc_en;
  logic          job_push;
  hjs_pkg::job_t job_in, job_head;
  logic          q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign acc_en    = push && !q_full;

  // per-string output byte limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 16'd511;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  // front: lead-byte decode, classify, offset / 28
  hjs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_en   (acc_en),
    .in_data  (in_data),
    .job_push (job_push),
    .job      (job_in)
  );

  // decoupling queue; only jobs that send bytes or end a string enter
  hjs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_job  (job_in),
    .rd_en   (q_pop),
    .rd_job  (job_head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // back: jamo lookup, byte serializer, limit, output register
  hjs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .limit    (limit_r),
    .head     (job_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

>>> verif/hjs_stream_checker.sv
// ----------------------------------------------------------------------------
// hjs_stream_checker: scoreboard for the Hangul jamo stream core
// Watches the request, result and limit channels, predicts the jamo byte
// stream of every accepted request and compares it with what the core sends.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hjs_stream_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic          full,
  input  hjs_pkg::in_t  in_data,
  input  logic          pop,
  input  logic          empty,
  input  hjs_pkg::out_t out_data,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [15:0]   cfg_data,
  output int            mismatch_count,
  output int            results_due
);

  localparam logic [20:0] SYL_FIRST    = 21'h00AC00;
  localparam logic [20:0] SYL_FINAL    = 21'h00D7A3;
  localparam int          TAIL_KINDS   = 28;
  localparam int          VOWEL_KINDS  = 21;
  localparam logic [15:0] VOWEL_FIRST  = 16'h314F;
  localparam int          RUN_MAX      = 9;
  localparam int          REPORT_MAX   = 10;
  localparam logic [15:0] LIMIT_RESET  = 16'd511;

  // compatibility jamo for leading consonants and trailing consonants
  logic [15:0] lead_jamo [0:18] = '{
    16'h3131, 16'h3132, 16'h3134, 16'h3137, 16'h3138, 16'h3139, 16'h3141,
    16'h3142, 16'h3143, 16'h3145, 16'h3146, 16'h3147, 16'h3148, 16'h3149,
    16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E};
  logic [15:0] tail_jamo [0:27] = '{
    16'h0000, 16'h3131, 16'h3132, 16'h3133, 16'h3134, 16'h3135, 16'h3136,
    16'h3137, 16'h3139, 16'h313A, 16'h313B, 16'h313C, 16'h313D, 16'h313E,
    16'h313F, 16'h3140, 16'h3141, 16'h3142, 16'h3144, 16'h3145, 16'h3146,
    16'h3147, 16'h3148, 16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E};

  // predicted core state
  logic [15:0]   byte_limit = LIMIT_RESET;
  logic [1:0]    seq_left   = 2'd0;
  logic [20:0]   code_acc   = 21'd0;
  logic [15:0]   sent_count = 16'd0;

  logic [7:0]    run_buf [0:RUN_MAX-1];
  int            run_len    = 0;
  int            results_seen = 0;
  hjs_pkg::out_t jamo_bytes_due [$];

  initial begin
    mismatch_count = 0;
    results_due    = 0;
  end

  function automatic void emit_byte(input logic [7:0] b);
    if (sent_count >= byte_limit || run_len >= RUN_MAX) return;
    run_buf[run_len] = b;
    run_len++;
    sent_count = sent_count + 16'd1;
  endfunction

  function automatic void emit_jamo(input logic [15:0] cp);
    emit_byte({4'hE, cp[15:12]});
    emit_byte({2'b10, cp[11:6]});
    emit_byte({2'b10, cp[5:0]});
  endfunction

  function automatic void finish_code(input logic [20:0] cp);
    int off;
    int tail;
    int vowel;
    int lead;
    if (cp < 21'h80) begin
      emit_byte(cp[7:0]);
    end else if (cp >= SYL_FIRST && cp <= SYL_FINAL) begin
      off   = int'(cp - SYL_FIRST);
      tail  = off % TAIL_KINDS;
      vowel = (off / TAIL_KINDS) % VOWEL_KINDS;
      lead  = (off / TAIL_KINDS) / VOWEL_KINDS;
      emit_jamo(lead_jamo[lead]);
      emit_jamo(VOWEL_FIRST + 16'(vowel));
      if (tail != 0) emit_jamo(tail_jamo[tail]);
    end
  endfunction

  function automatic void predict_jamo_bytes(input hjs_pkg::in_t req);
    logic [7:0]    b;
    hjs_pkg::out_t res;
    b = req.in_byte;
    run_len = 0;
    if (seq_left != 2'd0) begin
      // any byte is taken as continuation, low six bits only
      code_acc = {code_acc[14:0], b[5:0]};
      seq_left = seq_left - 2'd1;
      if (seq_left == 2'd0) finish_code(code_acc);
    end else if (b[7] == 1'b0) begin
      finish_code({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      code_acc = {16'd0, b[4:0]};
      seq_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      code_acc = {17'd0, b[3:0]};
      seq_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      code_acc = {18'd0, b[2:0]};
      seq_left = 2'd3;
    end
    for (int i = 0; i < run_len; i++) begin
      res.out_byte    = run_buf[i];
      res.last_of_run = (i == run_len - 1);
      jamo_bytes_due.push_back(res);
    end
    if (req.end_of_string) begin
      seq_left   = 2'd0;
      code_acc   = 21'd0;
      sent_count = 16'd0;
    end
  endfunction

  function automatic void flag_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("[%0t] MISMATCH %s", $time, msg);
  endfunction

  always @(posedge clk) begin : watch
    hjs_pkg::out_t want;
    if (!rst_n) begin
      byte_limit = LIMIT_RESET;
      seq_left   = 2'd0;
      code_acc   = 21'd0;
      sent_count = 16'd0;
      jamo_bytes_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) byte_limit = cfg_data;
      if (push && !full) predict_jamo_bytes(in_data);
      if (pop && !empty) begin
        results_seen++;
        if (jamo_bytes_due.size() == 0) begin
          flag_failure($sformatf("result %0d unexpected: out_byte %02h last_of_run %0b",
                                 results_seen, out_data.out_byte, out_data.last_of_run));
        end else begin
          want = jamo_bytes_due.pop_front();
          if (out_data.out_byte !== want.out_byte ||
              out_data.last_of_run !== want.last_of_run) begin
            flag_failure($sformatf(
              "result %0d: out_byte exp %02h got %02h, last_of_run exp %0b got %0b",
              results_seen, want.out_byte, out_data.out_byte,
              want.last_of_run, out_data.last_of_run));
          end
        end
      end
    end
    results_due = jamo_bytes_due.size();
  end

endmodule

>>> verif/tb_utf8_hangul_to_jamo_stream_core.sv
// ----------------------------------------------------------------------------
// tb_utf8_hangul_to_jamo_stream_core: testbench for the jamo stream core
// Feeds directed and random UTF-8 text through the request queue port under
// bursty input and a stalling reader, across several output byte limits;
// a scoreboard beside the core predicts and checks every output byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_utf8_hangul_to_jamo_stream_core;

  localparam logic [20:0] SYL_FIRST    = 21'h00AC00;
  localparam int          SYL_SPAN     = 11171;    // last syllable offset
  localparam int          HOLD_CYCLES  = 300;      // long reader hold-off
  localparam int          SETTLE_CYCLES = 40;      // drain of result-less jobs
  localparam int          WDOG_LIMIT   = 3000;
  localparam int          RUN_ITEMS    = 58;       // requests per random phase
  localparam int          RUN_PHASES   = 6;

  // reader stall patterns
  localparam int RX_FULL   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_EVERY4 = 2;
  localparam int RX_SPARSE = 3;

  logic          clk;
  logic          rst_n;
  logic          push;
  logic          full;
  hjs_pkg::in_t  in_data;
  logic          pop;
  logic          empty;
  hjs_pkg::out_t out_data;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [15:0]   cfg_data;

  int            mismatch_count;
  int            results_due;
  int            items_sent  = 0;
  int            burst_left  = 0;
  int            idle_cycles = 0;
  logic          hold_req;

  utf8_hangul_to_jamo_stream_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  hjs_stream_checker jamo_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data        (in_data),
    .pop            (pop),
    .empty          (empty),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Request side helpers. Every task is entered and left at a falling edge,
  // so push and in_data only ever change there.
  // --------------------------------------------------------------------------

  // One request. Bursts of random length with random gaps; push stays high
  // across a burst so it is never dropped and raised in the same step.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    push    <= 1'b1;
    in_data <= {b, eos};
    // full is read before the edge updates it: that is the accept condition
    do @(posedge clk); while (full);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  // UTF-8 encode cp in len bytes (2, 3 or 4) with no range checks, so
  // overlong forms fall out naturally. Only the first n_send bytes go out;
  // end_of_string rides on byte eos_at (-1: none).
  task automatic send_char(input logic [20:0] cp, input int len, input int n_send,
                           input int eos_at);
    logic [7:0] seq [0:3];
    case (len)
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < n_send; i++) send_byte(seq[i], i == eos_at);
  endtask

  // Quiesce: stop offering, let the scoreboard drain, then give trailing
  // result-less jobs time to leave the core.
  task automatic wait_idle();
    push <= 1'b0;
    burst_left = 0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random text: mostly well-formed characters (syllables dominate), with
  // non-syllable sequences, overlong forms, cut-off syllables and raw noise.
  task automatic send_text_run(input int target);
    int   pick;
    int   cut;
    logic eos_end;
    while (items_sent < target) begin
      pick    = $urandom_range(0, 99);
      eos_end = ($urandom_range(0, 7) == 0);
      if (pick < 20) begin
        send_byte(8'($urandom_range(0, 127)), eos_end);
      end else if (pick < 60) begin
        send_char(SYL_FIRST + 21'($urandom_range(0, SYL_SPAN)), 3, 3, eos_end ? 2 : -1);
      end else if (pick < 68) begin
        send_char(21'($urandom_range(0, 'h7FF)), 2, 2, eos_end ? 1 : -1);
      end else if (pick < 75) begin
        send_char(21'($urandom_range(0, 'hFFFF)), 3, 3, eos_end ? 2 : -1);
      end else if (pick < 80) begin
        send_char(21'($urandom_range(0, 'h1FFFFF)), 4, 4, eos_end ? 3 : -1);
      end else if (pick < 88) begin
        // cut-off syllable: unless eos ends it, the next character gets eaten as continuation
        cut = $urandom_range(1, 2);
        send_char(SYL_FIRST + 21'($urandom_range(0, SYL_SPAN)), 3, cut,
                  eos_end ? cut - 1 : -1);
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Reader: pop pattern changes after a random span; on hold_req it holds
  // off for a long stretch so the job queue fills and full rises.
  // --------------------------------------------------------------------------
  initial begin
    int mode;
    int span_left;
    int tick;
    pop       = 1'b0;
    mode      = RX_FULL;
    span_left = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (span_left == 0) begin
        mode      = $urandom_range(RX_FULL, RX_SPARSE);
        span_left = $urandom_range(8, 64);
      end
      span_left--;
      tick++;
      case (mode)
        RX_FULL:   pop <= 1'b1;
        RX_COIN:   pop <= 1'($urandom_range(0, 1));
        RX_EVERY4: pop <= (tick % 4 == 0);
        default:   pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Watchdog: any accepted request, result or limit write counts as progress.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("** utf8_hangul_to_jamo_stream_core: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    push      = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    hold_req  = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed text under the reset limit
    write_limit(16'd511);
    send_byte(8'h00, 1'b0);                   // NUL passes as ASCII
    send_byte(8'h7F, 1'b0);
    send_char(21'h000041, 2, 2, -1);          // overlong 'A' still passes
    send_char(21'h00AC00, 3, 3, -1);          // first syllable, no tail
    send_char(21'h00D7A3, 3, 3, -1);          // last syllable, last tail
    send_byte(8'h80, 1'b0);                   // stray continuation dropped
    send_byte(8'hFF, 1'b0);                   // invalid leads dropped
    send_byte(8'hF8, 1'b0);
    send_byte(8'hEA, 1'b0);                   // malformed continuation
    send_byte(8'h41, 1'b0);
    send_byte(8'h80, 1'b0);
    send_char(21'h000001, 4, 4, -1);          // 4-byte overlong control char
    send_char(21'h00AC00, 3, 2, 1);           // partial sequence cut by eos
    send_byte(8'h41, 1'b1);

    // limit cuts a syllable inside its second jamo set
    wait_idle();
    write_limit(16'd4);
    send_char(21'h00AC01, 3, 3, 2);

    // random phases across limits, extremes included; the first one runs
    // with a long reader hold-off so the core backs up into full
    for (int p = 0; p < RUN_PHASES; p++) begin
      wait_idle();
      case (p)
        0:       write_limit(16'hFFFF);
        1:       write_limit(16'd0);
        2:       write_limit(16'($urandom_range(1, 40)));
        3:       write_limit(16'd7);
        4:       write_limit(16'($urandom_range(0, 16'hFFFF)));
        default: write_limit(16'd511);
      endcase
      if (p == 0) hold_req = 1'b1;
      send_text_run(items_sent + RUN_ITEMS);
    end

    wait_idle();
    if (mismatch_count == 0 && results_due == 0) begin
      $display("** utf8_hangul_to_jamo_stream_core: PASSED **");
    end else begin
      $display("** utf8_hangul_to_jamo_stream_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
design/hjs_pkg.sv
design/hjs_front.sv
design/hjs_queue.sv
design/hjs_back.sv
design/utf8_hangul_to_jamo_stream_core.sv
verif/hjs_stream_checker.sv
verif/tb_utf8_hangul_to_jamo_stream_core.sv
